/* sv/khash_pkg.sv */
// Shared types and constants for the keyword hash table.
// Holds FNV-1a constants, operation and status codes, and the entry metadata type.
// No dependencies.
package khash_pkg;

   localparam int TABLE_SIZE_DEF  = 512;
   localparam int MAX_KEY_LEN_DEF = 32;

   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam int CNT_W  = 6;   // key length count, holds up to 63
   localparam int SLOT_W = 9;

   // operation codes of an input word
   localparam logic [1:0] KIND_INSERT = 2'd0;
   localparam logic [1:0] KIND_LOOKUP = 2'd1;
   localparam logic [1:0] KIND_CLEAR  = 2'd2;

   // result status codes
   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_LONG = 2'd2;

   typedef struct packed {
      logic             valid;
      logic [CNT_W-1:0] len;
      logic [7:0]       ttype;
   } meta_type;

   typedef struct packed {
      logic              found;
      logic [7:0]        rtype;
      logic [SLOT_W-1:0] slot;
      logic [1:0]        status;
   } res_type;

endpackage

/* sv/keyword_hash_table.sv */
// Keyword hash table: FNV-1a hash with linear probing over on-chip memories.
// Input channel req_* carries one key byte per word with its operation kind;
// result channel rsp_* carries one word per insert or lookup key.
// Bytes that are not last are taken one per cycle and give no result.
// On a last byte the hash is reduced to a start slot (the low bits for a power-of-two
// table, a reciprocal multiplication otherwise), then each probe reads the registered
// metadata and checks it, and a lookup compare or an insert copy handles one key byte
// per read and check or per read and write step.
// While a key is being resolved req_ready is low; the next key may start as soon
// as the result sits in the output register, even if rsp_ready is low.
// A clear word, and reset, start a sweep that invalidates all TABLE_SIZE entries;
// req_ready stays low during the sweep.
// A stalled receiver holds the result word; the block waits with its next result
// until the output register is free.
// Keys longer than MAX_KEY_LEN answer status 2 without touching the table.
// Depends on khash_pkg and khash_mod.
module keyword_hash_table #(
   parameter int TABLE_SIZE  = khash_pkg::TABLE_SIZE_DEF,
   parameter int MAX_KEY_LEN = khash_pkg::MAX_KEY_LEN_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic [7:0]                req_key_byte,
   input  logic                      req_last_byte,
   input  logic [7:0]                req_token_type,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_found,
   output logic [7:0]                rsp_result_type,
   output logic [khash_pkg::SLOT_W-1:0] rsp_slot,
   output logic [1:0]                rsp_status
);
   import khash_pkg::*;

   localparam int IDX_W    = $clog2(TABLE_SIZE);
   localparam int KW       = $clog2(MAX_KEY_LEN);
   localparam int EB_DEPTH = TABLE_SIZE * (1 << KW);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   typedef enum logic [9:0] {
      S_CLR     = 10'b00_0000_0001,
      S_IDLE    = 10'b00_0000_0010,
      S_HASH    = 10'b00_0000_0100,
      S_PRB_RD  = 10'b00_0000_1000,
      S_PRB_CHK = 10'b00_0001_0000,
      S_CMP_RD  = 10'b00_0010_0000,
      S_CMP_CHK = 10'b00_0100_0000,
      S_CPY_RD  = 10'b00_1000_0000,
      S_CPY_WR  = 10'b01_0000_0000,
      S_DONE    = 10'b10_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [31:0]        hash_ff, hash_in, hash_mix;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               long_ff, long_in;
   logic [CNT_W-1:0]   len_ff, len_in;
   logic               ins_ff, ins_in;
   logic [7:0]         ttype_ff, ttype_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [IDX_W-1:0]   n_ff, n_in;
   logic [IDX_W-1:0]   clr_ff, clr_in;
   logic [KW-1:0]      bi_ff, bi_in;
   res_type            res_ff, res_in;
   logic               rsp_valid_ff, rsp_valid_in;
   res_type            rsp_ff, rsp_in;

   logic               accept, last_key_byte, mod_start, mod_done;
   logic [IDX_W-1:0]   mod_idx;
   logic               kb_room;

   // memories
   logic [7:0]         kbuf_mem [MAX_KEY_LEN];
   logic [7:0]         kbuf_q;
   meta_type           meta_mem [TABLE_SIZE];
   meta_type           meta_q, meta_wd;
   logic               meta_we;
   logic [IDX_W-1:0]   meta_wa;
   logic [7:0]         eb_mem [EB_DEPTH];
   logic [7:0]         eb_q;
   logic               eb_we;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign kb_room   = (count_ff < CNT_W'(MAX_KEY_LEN));
   assign hash_mix  = 32'((hash_ff ^ {24'd0, req_key_byte}) * FNV_PRIME);
   assign last_key_byte = accept && req_last_byte &&
                          (req_kind == KIND_INSERT || req_kind == KIND_LOOKUP);
   assign mod_start = last_key_byte && !(long_ff || !kb_room);

   khash_mod #(.TABLE_SIZE(TABLE_SIZE)) u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .hash  (hash_mix),
      .done  (mod_done),
      .idx   (mod_idx)
   );

   // key buffer: written while bytes arrive, read during compare and copy
   always_ff @(posedge clock) begin
      if (accept && (req_kind == KIND_INSERT || req_kind == KIND_LOOKUP) && kb_room) begin
         kbuf_mem[count_ff[KW-1:0]] <= req_key_byte;
      end
      kbuf_q <= kbuf_mem[bi_ff];
   end

   // entry metadata
   always_ff @(posedge clock) begin
      if (meta_we) begin
         meta_mem[meta_wa] <= meta_wd;
      end
      meta_q <= meta_mem[idx_ff];
   end

   // stored key bytes, one row of 2^KW bytes per slot
   always_ff @(posedge clock) begin
      if (eb_we) begin
         eb_mem[{idx_ff, bi_ff}] <= kbuf_q;
      end
      eb_q <= eb_mem[{idx_ff, bi_ff}];
   end

   // control sequencer
   always_comb begin
      state_in     = state_ff;
      hash_in      = hash_ff;
      count_in     = count_ff;
      long_in      = long_ff;
      len_in       = len_ff;
      ins_in       = ins_ff;
      ttype_in     = ttype_ff;
      idx_in       = idx_ff;
      n_in         = n_ff;
      clr_in       = clr_ff;
      bi_in        = bi_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      meta_we      = 1'b0;
      meta_wa      = idx_ff;
      meta_wd      = '0;
      eb_we        = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLR: begin
            meta_we = 1'b1;
            meta_wa = clr_ff;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_IDX) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               if (req_kind == KIND_CLEAR) begin
                  hash_in  = FNV_BASIS;
                  count_in = '0;
                  long_in  = 1'b0;
                  clr_in   = '0;
                  state_in = S_CLR;
               end else if (req_kind == KIND_INSERT || req_kind == KIND_LOOKUP) begin
                  hash_in = hash_mix;
                  if (kb_room) begin
                     count_in = count_ff + 1'b1;
                  end else begin
                     long_in = 1'b1;
                  end
                  if (req_last_byte) begin
                     len_in   = kb_room ? count_ff + 1'b1 : count_ff;
                     ins_in   = (req_kind == KIND_INSERT);
                     ttype_in = req_token_type;
                     hash_in  = FNV_BASIS;
                     count_in = '0;
                     long_in  = 1'b0;
                     res_in   = '0;
                     if (long_ff || !kb_room) begin
                        res_in.status = ST_LONG;
                        state_in      = S_DONE;
                     end else begin
                        state_in = S_HASH;
                     end
                  end
               end
            end
         end
         S_HASH: begin
            if (mod_done) begin
               idx_in   = mod_idx;
               n_in     = '0;
               state_in = S_PRB_RD;
            end
         end
         S_PRB_RD: begin
            state_in = S_PRB_CHK;
         end
         S_PRB_CHK, S_CMP_CHK: begin
            if (state_ff == S_PRB_CHK && ins_ff && !meta_q.valid) begin
               // free slot: claim it, then copy the key
               meta_we       = 1'b1;
               meta_wd.valid = 1'b1;
               meta_wd.len   = len_ff;
               meta_wd.ttype = ttype_ff;
               bi_in         = '0;
               res_in.slot   = SLOT_W'(idx_ff);
               state_in      = S_CPY_RD;
            end else if (state_ff == S_PRB_CHK && !ins_ff && !meta_q.valid) begin
               state_in = S_DONE;   // empty slot ends a lookup
            end else if (state_ff == S_PRB_CHK && !ins_ff && meta_q.len == len_ff) begin
               bi_in    = '0;
               state_in = S_CMP_RD;
            end else if (state_ff == S_CMP_CHK && kbuf_q == eb_q) begin
               if (CNT_W'(bi_ff) == len_ff - 1'b1) begin
                  res_in.found = 1'b1;
                  res_in.rtype = meta_q.ttype;
                  res_in.slot  = SLOT_W'(idx_ff);
                  state_in     = S_DONE;
               end else begin
                  bi_in    = bi_ff + 1'b1;
                  state_in = S_CMP_RD;
               end
            end else begin
               // next slot, with wrap
               n_in   = n_ff + 1'b1;
               idx_in = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
               if (n_ff == LAST_IDX) begin
                  if (ins_ff) begin
                     res_in.status = ST_FULL;
                  end
                  state_in = S_DONE;
               end else begin
                  state_in = S_PRB_RD;
               end
            end
         end
         S_CMP_RD: begin
            state_in = S_CMP_CHK;
         end
         S_CPY_RD: begin
            state_in = S_CPY_WR;
         end
         S_CPY_WR: begin
            eb_we = 1'b1;
            if (CNT_W'(bi_ff) == len_ff - 1'b1) begin
               state_in = S_DONE;
            end else begin
               bi_in    = bi_ff + 1'b1;
               state_in = S_CPY_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         hash_ff      <= FNV_BASIS;
         count_ff     <= '0;
         long_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         long_ff      <= long_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff   <= len_in;
      ins_ff   <= ins_in;
      ttype_ff <= ttype_in;
      idx_ff   <= idx_in;
      n_ff     <= n_in;
      bi_ff    <= bi_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = rsp_ff.found;
   assign rsp_result_type = rsp_ff.rtype;
   assign rsp_slot        = rsp_ff.slot;
   assign rsp_status      = rsp_ff.status;

   // checks
   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && rsp_valid_ff && !rsp_ready) |=> state_ff == S_DONE)
      else $error("result dropped while output register busy");

   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_status == ST_OK))
      else $error("found word with error status");

   a_mod_in_hash: assert property (@(posedge clock) disable iff (reset)
      mod_done |-> (state_ff == S_HASH))
      else $error("slot reduction finished outside hash wait");

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLR) |-> !req_ready)
      else $error("input taken during clear sweep");

endmodule

/* sv/khash_mod.sv */
// Hash to start slot: hash modulo the table size.
// Power-of-two sizes take the low bits; other sizes use a reciprocal multiplication
// with one correction step; each step is registered. Depends on khash_pkg.
module khash_mod #(
   parameter int TABLE_SIZE = khash_pkg::TABLE_SIZE_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [31:0]                   hash,
   output logic                          done,
   output logic [$clog2(TABLE_SIZE)-1:0] idx
);
   import khash_pkg::*;

   localparam int  IDX_W   = $clog2(TABLE_SIZE);
   localparam int  RW      = IDX_W + 1;
   localparam bit  IS_POW2 = (TABLE_SIZE == (1 << IDX_W));
   localparam logic [RW-1:0] T_RW = RW'(TABLE_SIZE);
   localparam logic [31:0]   T_32 = 32'(TABLE_SIZE);
   // floor(2^(32+IDX_W) / TABLE_SIZE): quotient estimate is low by at most one
   localparam logic [32:0]   M_REC = 33'((64'd1 << (32 + IDX_W)) / 64'(TABLE_SIZE));
   localparam logic [15:0]   M_LO  = M_REC[15:0];
   localparam logic [16:0]   M_HI  = M_REC[32:16];

   logic [2:0]      stage_ff, stage_in;
   logic            done_ff, done_in;
   logic [31:0]     h_ff, h_in;
   logic [47:0]     plo_ff, plo_in;
   logic [48:0]     phi_ff, phi_in;
   logic [31:0]     q_ff, q_in;
   logic [RW-1:0]   r_ff, r_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [64:0]     prod;

   // split product, quotient estimate, partial remainder, final correction
   always_comb begin
      stage_in = {stage_ff[1:0], 1'b0};
      done_in  = 1'b0;
      h_in     = h_ff;
      plo_in   = plo_ff;
      phi_in   = phi_ff;
      q_in     = q_ff;
      r_in     = r_ff;
      rem_in   = rem_ff;
      prod     = {phi_ff, 16'd0} + {17'd0, plo_ff};
      if (start) begin
         if (IS_POW2) begin
            rem_in  = RW'(hash[IDX_W-1:0]);
            done_in = 1'b1;
         end else begin
            h_in        = hash;
            plo_in      = hash * M_LO;
            phi_in      = hash * M_HI;
            stage_in[0] = 1'b1;
         end
      end
      if (stage_ff[0]) begin
         q_in = 32'(prod >> (32 + IDX_W));
      end
      // below twice the table size here
      if (stage_ff[1]) begin
         r_in = RW'(h_ff - 32'(q_ff * T_32));
      end
      if (stage_ff[2]) begin
         rem_in  = (r_ff >= T_RW) ? r_ff - T_RW : r_ff;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      h_ff   <= h_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      q_ff   <= q_in;
      r_ff   <= r_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign idx  = rem_ff[IDX_W-1:0];

endmodule

/* tb/tb.sv */
// Testbench for keyword_hash_table: random and directed key words, self-checking.
// Holds a scoreboard class with its own FNV-1a table model and the driving tasks.
// Depends on khash_pkg and the keyword_hash_table RTL.
module tb;
   import khash_pkg::*;

   localparam int TSIZE  = TABLE_SIZE_DEF;
   localparam int KEYMAX = MAX_KEY_LEN_DEF;

   // unused operation code, ignored by the block
   localparam logic [1:0] KIND_SPARE = 2'd3;

   // table model and queue of pending results
   class hash_scoreboard;
      logic [31:0] hash_acc;
      int          byte_count;
      bit          too_long;
      logic [7:0]  key_buf [KEYMAX];
      meta_type    meta [TSIZE];
      logic [7:0]  bytes [TSIZE*KEYMAX];
      res_type     pending [$];
      int          errors;

      function void restart_key();
         hash_acc   = FNV_BASIS;
         byte_count = 0;
         too_long   = 0;
      endfunction

      function void reset_model();
         restart_key();
         foreach (meta[i]) meta[i] = '0;
         errors = 0;
      endfunction

      function bit slot_equal(int s, int len);
         if (meta[s].len != len) return 0;
         for (int i = 0; i < len; i++)
            if (bytes[s*KEYMAX+i] != key_buf[i]) return 0;
         return 1;
      endfunction

      // fold one accepted input word into the model
      function void note_word(logic [1:0] kind, logic [7:0] b, bit last, logic [7:0] tt);
         res_type r;
         int      idx;
         if (kind == KIND_SPARE) return;
         if (kind == KIND_CLEAR) begin
            foreach (meta[i]) meta[i] = '0;
            restart_key();
            return;
         end
         hash_acc = (hash_acc ^ {24'd0, b}) * FNV_PRIME;
         if (byte_count < KEYMAX) begin
            key_buf[byte_count] = b;
            byte_count++;
         end else begin
            too_long = 1;
         end
         if (!last) return;
         r   = '0;
         idx = int'(hash_acc % 32'(TSIZE));
         if (too_long) begin
            r.status = ST_LONG;
         end else if (kind == KIND_INSERT) begin
            r.status = ST_FULL;
            for (int n = 0; n < TSIZE; n++) begin
               if (!meta[idx].valid) begin
                  meta[idx].valid = 1;
                  meta[idx].len   = CNT_W'(byte_count);
                  meta[idx].ttype = tt;
                  for (int i = 0; i < byte_count; i++) bytes[idx*KEYMAX+i] = key_buf[i];
                  r.slot   = SLOT_W'(idx);
                  r.status = ST_OK;
                  break;
               end
               idx = (idx + 1) % TSIZE;
            end
         end else begin
            for (int n = 0; n < TSIZE; n++) begin
               if (!meta[idx].valid) break;
               if (slot_equal(idx, byte_count)) begin
                  r.found = 1;
                  r.rtype = meta[idx].ttype;
                  r.slot  = SLOT_W'(idx);
                  break;
               end
               idx = (idx + 1) % TSIZE;
            end
         end
         restart_key();
         pending.push_back(r);
      endfunction

      // compare one accepted result word with the oldest expectation
      function void check_result(logic f, logic [7:0] t, logic [8:0] s, logic [1:0] st);
         res_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word");
            errors++;
            return;
         end
         e = pending.pop_front();
         if (f !== e.found) begin
            $error("found exp %0d got %0d", e.found, f); errors++;
         end
         if (t !== e.rtype) begin
            $error("result_type exp %0d got %0d", e.rtype, t); errors++;
         end
         if (s !== e.slot) begin
            $error("slot exp %0d got %0d", e.slot, s); errors++;
         end
         if (st !== e.status) begin
            $error("status exp %0d got %0d", e.status, st); errors++;
         end
      endfunction
   endclass

   logic       clock, reset;
   logic       req_valid, req_ready, req_last_byte;
   logic [1:0] req_kind;
   logic [7:0] req_key_byte, req_token_type;
   logic       rsp_valid, rsp_ready, rsp_found;
   logic [7:0] rsp_result_type;
   logic [SLOT_W-1:0] rsp_slot;
   logic [1:0] rsp_status;

   hash_scoreboard sb;
   int  send_idle;     // percent of cycles the sender idles
   int  recv_idle;     // percent of cycles the receiver idles
   bit  hold_off;      // long receiver stall request
   int  cycles;

   keyword_hash_table DUT (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // cycle limit
   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > 3000000) begin
            $display("[keyword_hash_table] ERROR");
            $finish;
         end
      end
   end

   // result side: sample at rising edge, update ready at falling edge
   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready)
            sb.check_result(rsp_found, rsp_result_type, rsp_slot, rsp_status);
         @(negedge clock);
         if (hold_off) begin
            rsp_ready <= 0;
            for (int i = 0; i < 600; i++) @(negedge clock);
            hold_off = 0;
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // offer one word and wait for it to be taken; valid stays up for the next word
   task automatic send_word(logic [1:0] k, logic [7:0] b, bit last, logic [7:0] tt);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(negedge clock);
         while ($urandom_range(99) < send_idle) @(negedge clock);
      end
      req_valid      <= 1;
      req_kind       <= k;
      req_key_byte   <= b;
      req_last_byte  <= last;
      req_token_type <= tt;
      do @(posedge clock); while (!req_ready);
      sb.note_word(k, b, last, tt);
      @(negedge clock);
   endtask

   task automatic send_key(logic [1:0] k, logic [7:0] key[], logic [7:0] tt);
      foreach (key[i]) send_word(k, key[i], i == key.size() - 1, tt);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(negedge clock);
      repeat (50) @(negedge clock);
   endtask

   // random key drawn from a small alphabet so lookups hit
   function automatic void rand_key(ref logic [7:0] key[], input int maxlen);
      key = new[$urandom_range(maxlen, 1)];
      foreach (key[i]) key[i] = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                        : 8'(8'h61 + $urandom_range(3));
   endfunction

   initial begin
      logic [7:0] key[];
      logic [7:0] saved[$:63][];
      int         items;
      sb = new();
      sb.reset_model();
      send_idle = 0; recv_idle = 0; hold_off = 0;
      req_valid = 0; req_kind = KIND_INSERT; req_key_byte = 0;
      req_last_byte = 0; req_token_type = 0;
      reset = 1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: extremes, every kind, long key, duplicates, clear, kind three
      key = '{8'h00};           send_key(KIND_INSERT, key, 8'hFF);
      key = '{8'hFF};           send_key(KIND_INSERT, key, 8'h00);
      key = '{8'h00};           send_key(KIND_LOOKUP, key, 8'h55);
      key = '{8'hFF};           send_key(KIND_LOOKUP, key, 8'hAA);
      key = '{8'h12, 8'h34};    send_key(KIND_LOOKUP, key, 8'h00);
      key = '{8'h6B, 8'h77};    send_key(KIND_INSERT, key, 8'h01);
      key = '{8'h6B, 8'h77};    send_key(KIND_INSERT, key, 8'h02);
      key = '{8'h6B, 8'h77};    send_key(KIND_LOOKUP, key, 8'h00);
      key = new[KEYMAX];  foreach (key[i]) key[i] = 8'(i);  send_key(KIND_INSERT, key, 8'h7E);
      send_key(KIND_LOOKUP, key, 8'h00);
      key = new[KEYMAX+1]; foreach (key[i]) key[i] = 8'hA5; send_key(KIND_INSERT, key, 8'h3C);
      // mixed kinds: insert bytes ending in a lookup byte
      send_word(KIND_INSERT, 8'h00, 0, 8'h00);
      send_word(KIND_LOOKUP, 8'hFF, 1, 8'h00);
      send_word(KIND_SPARE, 8'hFF, 1, 8'hFF);
      send_word(KIND_INSERT, 8'h41, 0, 8'h00);
      send_word(KIND_CLEAR, 8'hFF, 1, 8'hFF);
      key = '{8'h6B, 8'h77}; send_key(KIND_LOOKUP, key, 8'h00);
      drain();

      // random phases with different idle mixes
      items = 0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = (ph == 0) ? 21 : (ph == 1) ? 84 : 0;
         recv_idle = (ph == 0) ? 84 : (ph == 1) ? 21 : 0;
         if (ph == 2) hold_off = 1;
         while (items < 170 * (ph + 1)) begin
            int r;
            r = $urandom_range(99);
            if (r < 40 || saved.size() == 0) begin
               rand_key(key, ($urandom_range(19) == 0) ? KEYMAX + 3 : 6);
               if (saved.size() < 60) saved.push_back(key);
               send_key(KIND_INSERT, key, 8'($urandom_range(255)));
            end else if (r < 80) begin
               key = saved[$urandom_range(saved.size() - 1)];
               send_key(KIND_LOOKUP, key, 8'($urandom_range(255)));
            end else if (r < 92) begin
               rand_key(key, 6);
               send_key(KIND_LOOKUP, key, 8'($urandom_range(255)));
            end else if (r < 97) begin
               key.delete();
               send_word(KIND_SPARE, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         8'($urandom_range(255)));
            end else begin
               key.delete();
               send_word(KIND_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                         8'($urandom_range(255)));
               saved.delete();
            end
            items += (key.size() > 0) ? key.size() : 1;
         end
         // sender waits for every pending result between phases
         drain();
      end

      // fill the table with one-byte keys until inserts report full, then clear it
      send_idle = 0; recv_idle = 0;
      for (int i = 0; i < TSIZE + 2; i++) begin
         key = '{i[7:0]};
         send_key(KIND_INSERT, key, i[7:0]);
      end
      key = '{8'h99, 8'h99, 8'h99}; send_key(KIND_LOOKUP, key, 8'h00);
      send_word(KIND_CLEAR, 8'h00, 0, 8'h00);
      key = '{8'h01, 8'h00}; send_key(KIND_LOOKUP, key, 8'h00);
      drain();

      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("[keyword_hash_table] OK");
      else
         $display("[keyword_hash_table] ERROR");
      $finish;
   end
endmodule

/* files.f */
sv/khash_pkg.sv
sv/khash_mod.sv
sv/keyword_hash_table.sv
tb/tb.sv
